FILE: src/mtsp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and byte classes for the MIME type/subtype parser.
// No dependencies.
package mtsp_pkg;

	localparam logic [2:0] PH_LEAD  = 3'd0;
	localparam logic [2:0] PH_TYPE  = 3'd1;
	localparam logic [2:0] PH_SUB   = 3'd2;
	localparam logic [2:0] PH_PARAM = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_TYPE  = 2'd1;
	localparam logic [1:0] KIND_SUB   = 2'd2;
	localparam logic [1:0] KIND_PARAM = 2'd3;

	localparam logic [1:0] VERD_UNDECIDED = 2'd0;
	localparam logic [1:0] VERD_ACCEPTED  = 2'd1;
	localparam logic [1:0] VERD_BAD_TYPE  = 2'd2;
	localparam logic [1:0] VERD_BAD_SUB   = 2'd3;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ASCII_TOP = 8'h7F;

	localparam int IDX_W = 12;

	// one classified beat between front and back
	typedef struct packed {
		logic [7:0] raw;
		logic [7:0] lowered;
		logic       last;
		logic       space;
		logic       token;
		logic       slash;
		logic       semi;
	} cls_t;

	// one result beat
	typedef struct packed {
		logic [7:0]       ch;
		logic [1:0]       kind;
		logic [1:0]       verdict;
		logic [IDX_W-1:0] ei;
		logic             none;
		logic [IDX_W-1:0] ps;
		logic             last;
	} res_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic logic is_token(input logic [7:0] c);
		logic r;
		r = 1'b0;
		if (c <= CH_ASCII_TOP) begin
			if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			    (c >= 8'h30 && c <= 8'h39))
				r = 1'b1;
			case (c)
				8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A,
				8'h2B, 8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C,
				8'h7E: r = 1'b1;
				default: ;
			endcase
		end
		return r;
	endfunction

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

endpackage

FILE: src/mtsp_front.sv
`timescale 1ns / 1ps
// Front stage: accepts input beats and registers their byte class.
// Depends on mtsp_pkg.
module mtsp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	output logic          cls_valid,
	input  logic          cls_ready,
	output mtsp_pkg::cls_t cls
);
	import mtsp_pkg::*;

	logic valid_s1;
	cls_t cls_s1;

	// hold while the queue is full
	assign in_stall  = valid_s1 && !cls_ready;
	assign cls_valid = valid_s1;
	assign cls       = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cls_s1.raw     <= in_byte;
			cls_s1.lowered <= lower(in_byte);
			cls_s1.last    <= in_last;
			cls_s1.space   <= is_space(in_byte);
			cls_s1.token   <= is_token(in_byte);
			cls_s1.slash   <= in_byte == CH_SLASH;
			cls_s1.semi    <= in_byte == CH_SEMI;
		end
	end

endmodule

FILE: src/mtsp_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of classified beats between front and back.
// Depends on mtsp_pkg.
module mtsp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  mtsp_pkg::cls_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output mtsp_pkg::cls_t pop_data
);
	import mtsp_pkg::*;

	cls_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) == (wr_ptr_q != rd_ptr_q)) else $error("queue pointers disagree");
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1 && pop && !push) |=> !pop_valid) else $error("queue not drained");
`endif

endmodule

FILE: src/mtsp_back.sv
`timescale 1ns / 1ps
// Back stage: phase machine over classified beats and the output register.
// Depends on mtsp_pkg.
module mtsp_back #(
	parameter int MAX_LEN = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cls_valid,
	output logic          cls_ready,
	input  mtsp_pkg::cls_t cls,
	output logic          out_valid,
	input  logic          out_stall,
	output mtsp_pkg::res_t res
);
	import mtsp_pkg::*;

	localparam int PW = $clog2(MAX_LEN);
	localparam logic [PW-1:0] TOP = PW'(MAX_LEN - 1);

	logic [2:0]    phase_q;
	logic [PW-1:0] pos_q;
	logic          token_seen_q;
	logic          pend_q;
	logic [PW-1:0] pend_idx_q;
	logic [PW-1:0] sub_start_q;

	logic          out_valid_q;
	res_t          res_q;

	logic [2:0]    phase_d;
	logic          token_seen_d;
	logic          pend_d;
	logic [PW-1:0] pend_idx_d;
	logic [PW-1:0] sub_start_d;
	logic [PW-1:0] pos_inc;
	logic [PW-1:0] ei;
	logic [PW-1:0] ps;
	res_t          r;
	logic          take;

	function automatic logic [IDX_W-1:0] idx12(input logic [PW-1:0] v);
		logic [PW+IDX_W-1:0] e;
		e = {{IDX_W{1'b0}}, v};
		return e[IDX_W-1:0];
	endfunction

	assign cls_ready = !out_valid_q || !out_stall;
	assign take      = cls_valid && cls_ready;
	assign pos_inc   = (pos_q == TOP) ? TOP : pos_q + PW'(1);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		phase_d      = phase_q;
		token_seen_d = token_seen_q;
		pend_d       = pend_q;
		pend_idx_d   = pend_idx_q;
		sub_start_d  = sub_start_q;
		ei           = '0;
		ps           = '0;
		r            = '0;
		r.last       = cls.last;
		case (phase_q)
			PH_LEAD: begin
				if (cls.space) begin
				end else if (cls.token) begin
					r.ch = cls.lowered; r.kind = KIND_TYPE; phase_d = PH_TYPE;
				end else begin
					r.verdict = VERD_BAD_TYPE; ei = pos_q; phase_d = PH_DONE;
				end
			end
			PH_TYPE: begin
				if (cls.slash) begin
					phase_d      = PH_SUB;
					sub_start_d  = pos_inc;
					token_seen_d = 1'b0;
					pend_d       = 1'b0;
					pend_idx_d   = '0;
				end else if (cls.token) begin
					r.ch = cls.lowered; r.kind = KIND_TYPE;
				end else begin
					r.verdict = VERD_BAD_TYPE; ei = pos_q; phase_d = PH_DONE;
				end
			end
			PH_SUB: begin
				if (cls.semi) begin
					if (token_seen_q) begin
						r.verdict = VERD_ACCEPTED; ps = pos_inc; phase_d = PH_PARAM;
					end else begin
						r.verdict = VERD_BAD_SUB; ei = sub_start_q; phase_d = PH_DONE;
					end
				end else if (cls.space) begin
					if (!pend_q) begin
						pend_d     = 1'b1;
						pend_idx_d = pos_q;
					end
				end else if (cls.token && !pend_q) begin
					r.ch = cls.lowered; r.kind = KIND_SUB; token_seen_d = 1'b1;
				end else begin
					r.verdict = VERD_BAD_SUB;
					ei        = pend_q ? pend_idx_q : pos_q;
					phase_d   = PH_DONE;
				end
			end
			PH_PARAM: begin
				r.ch = cls.raw; r.kind = KIND_PARAM;
			end
			default: ;
		endcase
		// close an open string on its final beat
		if (cls.last && r.verdict == VERD_UNDECIDED) begin
			if (phase_d == PH_LEAD || phase_d == PH_TYPE) begin
				r.verdict = VERD_BAD_TYPE; r.none = 1'b1; ei = '0;
			end else if (phase_d == PH_SUB) begin
				if (token_seen_d) begin
					r.verdict = VERD_ACCEPTED; ps = pos_inc;
				end else begin
					r.verdict = VERD_BAD_SUB; ei = sub_start_d;
				end
			end
		end
		r.ei = idx12(ei);
		r.ps = idx12(ps);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LEAD;
			pos_q        <= '0;
			token_seen_q <= 1'b0;
			pend_q       <= 1'b0;
			pend_idx_q   <= '0;
			sub_start_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cls_ready) out_valid_q <= cls_valid;
			if (take) begin
				if (cls.last) begin
					phase_q      <= PH_LEAD;
					pos_q        <= '0;
					token_seen_q <= 1'b0;
					pend_q       <= 1'b0;
					pend_idx_q   <= '0;
					sub_start_q  <= '0;
				end else begin
					phase_q      <= phase_d;
					pos_q        <= pos_inc;
					token_seen_q <= token_seen_d;
					pend_q       <= pend_d;
					pend_idx_q   <= pend_idx_d;
					sub_start_q  <= sub_start_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_q <= r;
	end

`ifndef SYNTHESIS
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cls.last) |=> (phase_q == PH_LEAD && pos_q == '0))
		else $error("state not cleared after final beat");
	a_none_bad_type: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.none) |-> res_q.verdict == VERD_BAD_TYPE)
		else $error("no-slash flag without type verdict");
	a_param_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.kind == KIND_PARAM) |-> res_q.verdict == VERD_UNDECIDED)
		else $error("parameter beat carries a verdict");
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= TOP) else $error("byte position past its limit");
`endif

endmodule

FILE: src/mime_type_subtype_parser.sv
`timescale 1ns / 1ps
// MIME type/subtype parser, one byte per beat, one result beat per input beat.
// Path from input accept to result valid: front register, two-entry queue,
// back output register. Throughput: one byte per cycle while out_stall is
// low, set by the back phase machine, which updates state on each taken beat.
// Reset: arst_n clears all control and parser state asynchronously.
module mime_type_subtype_parser #(
	parameter int MAX_LEN = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_char,
	output logic [1:0]  char_kind,
	output logic [1:0]  verdict,
	output logic [11:0] error_index,
	output logic        error_index_none,
	output logic [11:0] params_start,
	output logic        out_last
);
	import mtsp_pkg::*;

	logic f_valid;
	logic f_ready;
	cls_t f_cls;
	logic q_valid;
	logic q_ready;
	cls_t q_cls;
	res_t res;

	mtsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.cls_valid (f_valid),
		.cls_ready (f_ready),
		.cls       (f_cls)
	);

	mtsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_cls),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_cls)
	);

	mtsp_back #(.MAX_LEN(MAX_LEN)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (q_valid),
		.cls_ready (q_ready),
		.cls       (q_cls),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign out_char         = res.ch;
	assign char_kind        = res.kind;
	assign verdict          = res.verdict;
	assign error_index      = res.ei;
	assign error_index_none = res.none;
	assign params_start     = res.ps;
	assign out_last         = res.last;

endmodule
